// ===== hdl/sgd_pkg.sv =====
// Shared types and constants for the SPI gate-driver register access unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sgd_pkg;

   // Field widths
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 11;
   localparam int FRAME_W = 16;
   localparam int CFG_W   = 10;
   localparam int BIT_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Stream packing
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 16;

   // Parameter defaults
   localparam int DELAY_WIDTH_DEFAULT = 10;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CS_SETUP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CS_HOLD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CS_GAP   = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0] PHASE_RST    = 10'd5;
   localparam logic [CFG_W-1:0] CS_SETUP_RST = 10'd10;
   localparam logic [CFG_W-1:0] CS_HOLD_RST  = 10'd10;
   localparam logic [CFG_W-1:0] CS_GAP_RST   = 10'd1;

   // One decoded tick, as handed from the front to the sequencer
   typedef struct packed {
      logic               start;
      logic               is_read;
      logic [FRAME_W-1:0] frame;
      logic               miso;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/sgd_front.sv =====
// Front end: unpacks request items and builds the first SPI frame word.
// Depends on sgd_pkg.
`default_nettype none

module sgd_front (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [sgd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [sgd_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  wire logic                             queue_full,
   output logic                                  push,
   output sgd_pkg::cmd_type                      push_cmd
);
   import sgd_pkg::*;

   logic [ADDR_W-1:0] reg_addr;
   logic [DATA_W-1:0] write_data;

   assign reg_addr   = req_tdata[4:1];
   assign write_data = req_tdata[15:5];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_cmd.start   = req_tdata[0];
      push_cmd.is_read = req_tuser[0];
      push_cmd.miso    = req_tdata[16];
      // read command frame carries only the address; write carries the data too
      if (req_tuser[0]) begin
         push_cmd.frame = {1'b1, reg_addr, {DATA_W{1'b0}}};
      end else begin
         push_cmd.frame = {1'b0, reg_addr, write_data};
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sgd_queue.sv =====
// Short FIFO of decoded ticks between the front end and the sequencer.
// Depends on sgd_pkg.
`default_nettype none

module sgd_queue #(
   parameter int QUEUE_DEPTH = sgd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sgd_pkg::cmd_type push_cmd,
   output logic                  full,
   output logic                  pop_valid,
   input  wire logic             pop,
   output sgd_pkg::cmd_type      pop_cmd
);
   import sgd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sgd_back.sv =====
// Back end: SPI frame sequencer, timing registers and the registered result stage.
// Depends on sgd_pkg.
`default_nettype none

module sgd_back #(
   parameter int DELAY_WIDTH = sgd_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  wire sgd_pkg::cmd_type                 cmd,
   output logic                                  cmd_pop,
   input  wire logic                             csr_we,
   input  wire logic [sgd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgd_pkg::CFG_W-1:0]        csr_wdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [sgd_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import sgd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_LOWA  = 3'd2;
   localparam logic [2:0] ST_LOWB  = 3'd3;
   localparam logic [2:0] ST_HIGH  = 3'd4;
   localparam logic [2:0] ST_LOWC  = 3'd5;
   localparam logic [2:0] ST_HOLD  = 3'd6;
   localparam logic [2:0] ST_GAP   = 3'd7;

   logic [CFG_W-1:0] phase_ff, setup_ff, hold_ff, gap_ff;

   logic [2:0]             state_ff, state_in;
   logic [DELAY_WIDTH-1:0] timer_ff, timer_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [FRAME_W-1:0]     tx_ff, tx_in;
   logic [FRAME_W-1:0]     rx_ff, rx_in;
   logic                   pend_ff, pend_in;
   logic                   acc_rd_ff, acc_rd_in;
   logic [DATA_W-1:0]      last_rd_ff, last_rd_in;
   logic                   cs_n_ff, cs_n_in;
   logic                   sclk_ff, sclk_in;
   logic                   mosi_ff, mosi_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   fire;
   logic                   done;
   logic [DATA_W-1:0]      rd;

   // advance one queued tick whenever the result slot is free or being drained
   assign fire    = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_pop = fire;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RST;
         setup_ff <= CS_SETUP_RST;
         hold_ff  <= CS_HOLD_RST;
         gap_ff   <= CS_GAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE:    phase_ff <= csr_wdata;
            CSR_CS_SETUP: setup_ff <= csr_wdata;
            CSR_CS_HOLD:  hold_ff  <= csr_wdata;
            CSR_CS_GAP:   gap_ff   <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      timer_in   = timer_ff;
      bit_in     = bit_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      pend_in    = pend_ff;
      acc_rd_in  = acc_rd_ff;
      last_rd_in = last_rd_ff;
      cs_n_in    = cs_n_ff;
      sclk_in    = sclk_ff;
      mosi_in    = mosi_ff;
      done       = 1'b0;
      rd         = '0;

      if (fire) begin
         if (state_ff == ST_IDLE) begin
            if (cmd.start) begin
               pend_in   = cmd.is_read;
               acc_rd_in = cmd.is_read;
               tx_in     = cmd.frame;
               rx_in     = '0;
               bit_in    = '0;
               cs_n_in   = 1'b0;
               state_in  = ST_SETUP;
               timer_in  = DELAY_WIDTH'(setup_ff);
            end
         end else if (timer_ff > DELAY_WIDTH'(1)) begin
            timer_in = timer_ff - DELAY_WIDTH'(1);
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
               end
               ST_SETUP: begin
                  sclk_in  = 1'b0;
                  state_in = ST_LOWA;
                  timer_in = DELAY_WIDTH'(phase_ff);
               end
               ST_LOWA: begin
                  mosi_in  = tx_ff[FRAME_W-1];
                  state_in = ST_LOWB;
                  timer_in = DELAY_WIDTH'(phase_ff);
               end
               ST_LOWB: begin
                  sclk_in  = 1'b1;
                  state_in = ST_HIGH;
                  timer_in = DELAY_WIDTH'(phase_ff);
               end
               ST_HIGH: begin
                  sclk_in  = 1'b0;
                  rx_in    = {rx_ff[FRAME_W-2:0], cmd.miso};
                  state_in = ST_LOWC;
                  timer_in = DELAY_WIDTH'(phase_ff);
               end
               ST_LOWC: begin
                  tx_in = {tx_ff[FRAME_W-2:0], 1'b0};
                  if (bit_ff == {BIT_W{1'b1}}) begin
                     bit_in   = '0;
                     state_in = ST_HOLD;
                     timer_in = DELAY_WIDTH'(hold_ff);
                  end else begin
                     bit_in   = bit_ff + BIT_W'(1);
                     state_in = ST_LOWA;
                     timer_in = DELAY_WIDTH'(phase_ff);
                  end
               end
               ST_HOLD: begin
                  cs_n_in = 1'b1;
                  mosi_in = 1'b0;
                  // capture only at the end of the dummy frame of a read
                  if (acc_rd_ff && !pend_ff) begin
                     last_rd_in = rx_ff[DATA_W-1:0];
                  end
                  state_in = ST_GAP;
                  timer_in = DELAY_WIDTH'(gap_ff);
               end
               ST_GAP: begin
                  if (pend_ff) begin
                     pend_in  = 1'b0;
                     tx_in    = '0;
                     rx_in    = '0;
                     bit_in   = '0;
                     cs_n_in  = 1'b0;
                     state_in = ST_SETUP;
                     timer_in = DELAY_WIDTH'(setup_ff);
                  end else begin
                     state_in = ST_IDLE;
                     timer_in = '0;
                     done     = 1'b1;
                     if (acc_rd_ff) begin
                        rd = last_rd_ff;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rd, done, (state_in != ST_IDLE), mosi_in, sclk_in, cs_n_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timer_ff     <= '0;
         bit_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         pend_ff      <= 1'b0;
         acc_rd_ff    <= 1'b0;
         last_rd_ff   <= '0;
         cs_n_ff      <= 1'b1;
         sclk_ff      <= 1'b0;
         mosi_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         bit_ff       <= bit_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         pend_ff      <= pend_in;
         acc_rd_ff    <= acc_rd_in;
         last_rd_ff   <= last_rd_in;
         cs_n_ff      <= cs_n_in;
         sclk_ff      <= sclk_in;
         mosi_ff      <= mosi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/spi_gate_driver_register_access_unit.sv =====
// SPI gate-driver register access unit: one request item per timing tick, one result per tick.
// Path: an accepted item is written into the queue, then popped into the registered result
// stage, from which it is taken; it waits in the queue while that stage is held.
// Throughput: the sequencer pops one tick per cycle while the result slot is free or drained.
// Reset (synchronous, active high): queue empty, sequencer idle, cs_n high, sclk and mosi
// low, timing registers back to phase 5, setup 10, hold 10, gap 1.
// Depends on sgd_pkg, sgd_front, sgd_queue, sgd_back.
`default_nettype none

module spi_gate_driver_register_access_unit #(
   parameter int DELAY_WIDTH = sgd_pkg::DELAY_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = sgd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [0] start_req, [4:1] reg_addr, [15:5] write_data, [16] miso, [23:17] zero
   input  wire logic [sgd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] is_read
   input  wire logic [sgd_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] cs_n, [1] sclk, [2] mosi, [3] busy_res, [4] done_res, [15:5] read_data
   output logic [sgd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [sgd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgd_pkg::CFG_W-1:0]        csr_wdata
);
   import sgd_pkg::*;

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   sgd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sgd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_cmd   (pop_cmd)
   );

   sgd_back #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
